[hdl/pocd_pkg.sv]
package pocd_pkg;

	localparam int CLS_W = 6;

	typedef logic [CLS_W-1:0] cls_code_t;

	// Prefix bytes that select a prefixed opcode map.
	localparam logic [7:0] PFX_CB = 8'hCB;
	localparam logic [7:0] PFX_DD = 8'hDD;
	localparam logic [7:0] PFX_FD = 8'hFD;
	localparam logic [7:0] PFX_FC = 8'hFC;

	// Instruction classes.
	localparam cls_code_t CLS_BIT  = 6'd0;
	localparam cls_code_t CLS_RES  = 6'd1;
	localparam cls_code_t CLS_SET  = 6'd2;
	localparam cls_code_t CLS_RLC  = 6'd3;
	localparam cls_code_t CLS_RL   = 6'd4;
	localparam cls_code_t CLS_RRC  = 6'd5;
	localparam cls_code_t CLS_RR   = 6'd6;
	localparam cls_code_t CLS_SLA  = 6'd7;
	localparam cls_code_t CLS_SRA  = 6'd8;
	localparam cls_code_t CLS_SRL  = 6'd9;
	localparam cls_code_t CLS_SWAP = 6'd10;
	localparam cls_code_t CLS_LD   = 6'd11;
	localparam cls_code_t CLS_JPU  = 6'd12;
	localparam cls_code_t CLS_NOP  = 6'd13;
	localparam cls_code_t CLS_STOP = 6'd14;
	localparam cls_code_t CLS_RLCA = 6'd15;
	localparam cls_code_t CLS_RLA  = 6'd16;
	localparam cls_code_t CLS_DAA  = 6'd17;
	localparam cls_code_t CLS_CPL  = 6'd18;
	localparam cls_code_t CLS_CCF  = 6'd19;
	localparam cls_code_t CLS_SCF  = 6'd20;
	localparam cls_code_t CLS_JR   = 6'd21;
	localparam cls_code_t CLS_HALT = 6'd22;
	localparam cls_code_t CLS_JP   = 6'd23;
	localparam cls_code_t CLS_RRCA = 6'd24;
	localparam cls_code_t CLS_RRA  = 6'd25;
	localparam cls_code_t CLS_ADD  = 6'd26;
	localparam cls_code_t CLS_RET  = 6'd27;
	localparam cls_code_t CLS_RETI = 6'd28;
	localparam cls_code_t CLS_RST  = 6'd29;
	localparam cls_code_t CLS_CALL = 6'd30;
	localparam cls_code_t CLS_ADC  = 6'd31;
	localparam cls_code_t CLS_SUB  = 6'd32;
	localparam cls_code_t CLS_SBC  = 6'd33;
	localparam cls_code_t CLS_AND  = 6'd34;
	localparam cls_code_t CLS_OR   = 6'd35;
	localparam cls_code_t CLS_XOR  = 6'd36;
	localparam cls_code_t CLS_LDHL = 6'd37;
	localparam cls_code_t CLS_EI   = 6'd38;
	localparam cls_code_t CLS_DI   = 6'd39;
	localparam cls_code_t CLS_CP   = 6'd40;
	localparam cls_code_t CLS_INC  = 6'd41;
	localparam cls_code_t CLS_DEC  = 6'd42;
	localparam cls_code_t CLS_PUSH = 6'd43;
	localparam cls_code_t CLS_POP  = 6'd44;
	localparam cls_code_t CLS_LAST = CLS_POP;

	typedef struct packed {
		logic [7:0] opcode_byte;
		logic       prefix_valid;
		logic [7:0] prefix_byte;
	} op_t;

	typedef struct packed {
		cls_code_t instr_class;
		logic      unknown;
	} cls_t;

endpackage

[hdl/pocd_decoder.sv]
module pocd_decoder (
	input  pocd_pkg::op_t  op,
	output pocd_pkg::cls_t cls
);

	logic                pfx_cb;
	logic                pfx_ddfd;
	logic                pfx_fc;
	logic                tbl_hit;
	pocd_pkg::cls_code_t tbl_cls;
	logic                load_hit;

	assign pfx_cb   = op.prefix_valid && (op.prefix_byte == pocd_pkg::PFX_CB);
	assign pfx_ddfd = op.prefix_valid && ((op.prefix_byte == pocd_pkg::PFX_DD) ||
		(op.prefix_byte == pocd_pkg::PFX_FD));
	assign pfx_fc   = op.prefix_valid && (op.prefix_byte == pocd_pkg::PFX_FC);

	// Selected map; case arms are tried top to bottom, so the first match wins.
	always_comb begin
		tbl_hit = 1'b1;
		tbl_cls = pocd_pkg::CLS_BIT;
		if (pfx_cb) begin
			casez (op.opcode_byte)
				8'b01??????: tbl_cls = pocd_pkg::CLS_BIT;
				8'b10??????: tbl_cls = pocd_pkg::CLS_RES;
				8'b11??????: tbl_cls = pocd_pkg::CLS_SET;
				8'b00000???: tbl_cls = pocd_pkg::CLS_RLC;
				8'b00010???: tbl_cls = pocd_pkg::CLS_RL;
				8'b00001???: tbl_cls = pocd_pkg::CLS_RRC;
				8'b00011???: tbl_cls = pocd_pkg::CLS_RR;
				8'b00100???: tbl_cls = pocd_pkg::CLS_SLA;
				8'b00101???: tbl_cls = pocd_pkg::CLS_SRA;
				8'b00111???: tbl_cls = pocd_pkg::CLS_SRL;
				8'b00110???: tbl_cls = pocd_pkg::CLS_SWAP;
				default:     tbl_hit = 1'b0;
			endcase
		end else if (pfx_ddfd) begin
			casez (op.opcode_byte)
				8'b01???110: tbl_cls = pocd_pkg::CLS_LD;
				8'b01110???: tbl_cls = pocd_pkg::CLS_LD;
				default:     tbl_hit = 1'b0;
			endcase
		end else if (pfx_fc) begin
			casez (op.opcode_byte)
				8'b11000011: tbl_cls = pocd_pkg::CLS_JPU;
				default:     tbl_hit = 1'b0;
			endcase
		end else begin
			casez (op.opcode_byte)
				8'b00000000: tbl_cls = pocd_pkg::CLS_NOP;
				8'b00010000: tbl_cls = pocd_pkg::CLS_STOP;
				8'b00000111: tbl_cls = pocd_pkg::CLS_RLCA;
				8'b00010111: tbl_cls = pocd_pkg::CLS_RLA;
				8'b00100111: tbl_cls = pocd_pkg::CLS_DAA;
				8'b00101111: tbl_cls = pocd_pkg::CLS_CPL;
				8'b00111111: tbl_cls = pocd_pkg::CLS_CCF;
				8'b00110111: tbl_cls = pocd_pkg::CLS_SCF;
				8'b00011000: tbl_cls = pocd_pkg::CLS_JR;
				8'b001??000: tbl_cls = pocd_pkg::CLS_JR;
				8'b01110110: tbl_cls = pocd_pkg::CLS_HALT;
				8'b11101001: tbl_cls = pocd_pkg::CLS_JP;
				8'b110??01?: tbl_cls = pocd_pkg::CLS_JP;
				8'b00001111: tbl_cls = pocd_pkg::CLS_RRCA;
				8'b00011111: tbl_cls = pocd_pkg::CLS_RRA;
				8'b00??1001: tbl_cls = pocd_pkg::CLS_ADD;
				8'b10000???: tbl_cls = pocd_pkg::CLS_ADD;
				8'b11000110: tbl_cls = pocd_pkg::CLS_ADD;
				8'b11101000: tbl_cls = pocd_pkg::CLS_ADD;
				8'b110??000: tbl_cls = pocd_pkg::CLS_RET;
				8'b11001001: tbl_cls = pocd_pkg::CLS_RET;
				8'b11011001: tbl_cls = pocd_pkg::CLS_RETI;
				8'b11???111: tbl_cls = pocd_pkg::CLS_RST;
				8'b11001101: tbl_cls = pocd_pkg::CLS_CALL;
				8'b110??100: tbl_cls = pocd_pkg::CLS_CALL;
				8'b11001110: tbl_cls = pocd_pkg::CLS_ADC;
				8'b10001???: tbl_cls = pocd_pkg::CLS_ADC;
				8'b10010???: tbl_cls = pocd_pkg::CLS_SUB;
				8'b11010110: tbl_cls = pocd_pkg::CLS_SUB;
				8'b11011110: tbl_cls = pocd_pkg::CLS_SBC;
				8'b10011???: tbl_cls = pocd_pkg::CLS_SBC;
				8'b11100110: tbl_cls = pocd_pkg::CLS_AND;
				8'b10100???: tbl_cls = pocd_pkg::CLS_AND;
				8'b11110110: tbl_cls = pocd_pkg::CLS_OR;
				8'b10110???: tbl_cls = pocd_pkg::CLS_OR;
				8'b11101110: tbl_cls = pocd_pkg::CLS_XOR;
				8'b10101???: tbl_cls = pocd_pkg::CLS_XOR;
				8'b11111000: tbl_cls = pocd_pkg::CLS_LDHL;
				8'b11111011: tbl_cls = pocd_pkg::CLS_EI;
				8'b11110011: tbl_cls = pocd_pkg::CLS_DI;
				8'b11111110: tbl_cls = pocd_pkg::CLS_CP;
				8'b10111???: tbl_cls = pocd_pkg::CLS_CP;
				8'b00???100: tbl_cls = pocd_pkg::CLS_INC;
				8'b00??0011: tbl_cls = pocd_pkg::CLS_INC;
				8'b00???101: tbl_cls = pocd_pkg::CLS_DEC;
				8'b00??1011: tbl_cls = pocd_pkg::CLS_DEC;
				8'b11??0101: tbl_cls = pocd_pkg::CLS_PUSH;
				8'b11??0001: tbl_cls = pocd_pkg::CLS_POP;
				default:     tbl_hit = 1'b0;
			endcase
		end
	end

	// Load forms serve as the fallback for the unprefixed and FC maps.
	always_comb begin
		casez (op.opcode_byte)
			8'b00001000,
			8'b00??0001,
			8'b00???110,
			8'b00??1010,
			8'b00??0010,
			8'b01??????,
			8'b111?0010,
			8'b111?0000,
			8'b111?1010,
			8'b11111001: load_hit = 1'b1;
			default:     load_hit = 1'b0;
		endcase
	end

	always_comb begin
		cls.instr_class = pocd_pkg::CLS_BIT;
		cls.unknown     = 1'b0;
		if (tbl_hit) begin
			cls.instr_class = tbl_cls;
		end else if (!pfx_cb && !pfx_ddfd && load_hit) begin
			cls.instr_class = pocd_pkg::CLS_LD;
		end else begin
			cls.unknown = 1'b1;
		end
	end

endmodule

[hdl/prefixed_opcode_class_decoder_unit.sv]
// Path: an accepted opcode item is held in op_s1, decoded, and held in cls_s2 before output.
// Throughput: one item per cycle while the output drains; a stalled result holds the
// input register, and the input stalls only when that register is full as well.
// Reset: arst_n clears both stage valid flags at once; the data registers are not reset.
module prefixed_opcode_class_decoder_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op_valid,
	output logic           op_stall,
	input  pocd_pkg::op_t  op,
	output logic           cls_valid,
	input  logic           cls_stall,
	output pocd_pkg::cls_t cls
);

	logic           valid_s1;
	pocd_pkg::op_t  op_s1;
	logic           valid_s2;
	pocd_pkg::cls_t cls_s2;
	pocd_pkg::cls_t dec_cls;
	logic           adv_s1;
	logic           adv_s2;

	assign adv_s2   = !valid_s2 || !cls_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign op_stall = !adv_s1;

	pocd_decoder u_decoder (
		.op  (op_s1),
		.cls (dec_cls)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= op_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && op_valid) begin
			op_s1 <= op;
		end
		if (adv_s2 && valid_s1) begin
			cls_s2 <= dec_cls;
		end
	end

	assign cls_valid = valid_s2;
	assign cls       = cls_s2;

endmodule

[hdl/pocd_checker.sv]
module pocd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           op_valid,
	input logic           op_stall,
	input pocd_pkg::op_t  op,
	input logic           cls_valid,
	input logic           cls_stall,
	input pocd_pkg::cls_t cls
);

	// An offered item waits unchanged while it is stalled.
	a_op_hold: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && op_stall |=> op_valid && $stable(op))
		else $error("opcode item changed while stalled");

	// A result that is held back stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cls_valid && cls_stall |=> cls_valid && $stable(cls))
		else $error("class item changed while stalled");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cls_valid && cls.unknown |-> cls.instr_class == pocd_pkg::CLS_BIT)
		else $error("unknown item carries a nonzero class");

	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		cls_valid && !cls.unknown |-> cls.instr_class <= pocd_pkg::CLS_LAST)
		else $error("class out of range");

	// An accepted item passes through both stages and reaches the output when the output drains.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(op_valid && !op_stall) ##1 !cls_stall |=> cls_valid)
		else $error("accepted item did not reach the output");

endmodule

bind prefixed_opcode_class_decoder_unit pocd_checker u_pocd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.op_valid  (op_valid),
	.op_stall  (op_stall),
	.op        (op),
	.cls_valid (cls_valid),
	.cls_stall (cls_stall),
	.cls       (cls)
);

[tb/tb_prefixed_opcode_class_decoder_unit.sv]
`timescale 1ns / 100ps

// Holds the classes expected for accepted opcode items, oldest first.
class opcode_class_tracker;
	pocd_pkg::cls_t expected_classes[$];
	int mismatch_count;

	function new();
		mismatch_count = 0;
	endfunction

	function bit match_cb(input logic [7:0] opc, output pocd_pkg::cls_code_t c);
		match_cb = 1'b1;
		casez (opc)
			8'b01??????: c = pocd_pkg::CLS_BIT;
			8'b10??????: c = pocd_pkg::CLS_RES;
			8'b11??????: c = pocd_pkg::CLS_SET;
			8'b00000???: c = pocd_pkg::CLS_RLC;
			8'b00010???: c = pocd_pkg::CLS_RL;
			8'b00001???: c = pocd_pkg::CLS_RRC;
			8'b00011???: c = pocd_pkg::CLS_RR;
			8'b00100???: c = pocd_pkg::CLS_SLA;
			8'b00101???: c = pocd_pkg::CLS_SRA;
			8'b00111???: c = pocd_pkg::CLS_SRL;
			8'b00110???: c = pocd_pkg::CLS_SWAP;
			default: begin
				c = '0;
				match_cb = 1'b0;
			end
		endcase
	endfunction

	function bit match_index_load(input logic [7:0] opc);
		casez (opc)
			8'b01???110, 8'b01110???: match_index_load = 1'b1;
			default: match_index_load = 1'b0;
		endcase
	endfunction

	// The load map is the fallback for the unprefixed and system-mode maps.
	function bit match_load(input logic [7:0] opc);
		casez (opc)
			8'b00001000, 8'b00??0001, 8'b001?1010, 8'b001?0010,
			8'b00???110, 8'b000?1010, 8'b000?0010, 8'b111?0010,
			8'b111?0000, 8'b111?1010, 8'b11111001, 8'b01??????:
				match_load = 1'b1;
			default: match_load = 1'b0;
		endcase
	endfunction

	// First matching pattern wins, so the order of the items matters.
	function bit match_plain(input logic [7:0] opc, output pocd_pkg::cls_code_t c);
		match_plain = 1'b1;
		casez (opc)
			8'b00000000: c = pocd_pkg::CLS_NOP;
			8'b00010000: c = pocd_pkg::CLS_STOP;
			8'b00000111: c = pocd_pkg::CLS_RLCA;
			8'b00010111: c = pocd_pkg::CLS_RLA;
			8'b00100111: c = pocd_pkg::CLS_DAA;
			8'b00101111: c = pocd_pkg::CLS_CPL;
			8'b00111111: c = pocd_pkg::CLS_CCF;
			8'b00110111: c = pocd_pkg::CLS_SCF;
			8'b00011000: c = pocd_pkg::CLS_JR;
			8'b001??000: c = pocd_pkg::CLS_JR;
			8'b01110110: c = pocd_pkg::CLS_HALT;
			8'b11101001: c = pocd_pkg::CLS_JP;
			8'b110??01?: c = pocd_pkg::CLS_JP;
			8'b00001111: c = pocd_pkg::CLS_RRCA;
			8'b00011111: c = pocd_pkg::CLS_RRA;
			8'b00??1001: c = pocd_pkg::CLS_ADD;
			8'b10000???: c = pocd_pkg::CLS_ADD;
			8'b11000110: c = pocd_pkg::CLS_ADD;
			8'b11101000: c = pocd_pkg::CLS_ADD;
			8'b110??000: c = pocd_pkg::CLS_RET;
			8'b11001001: c = pocd_pkg::CLS_RET;
			8'b11011001: c = pocd_pkg::CLS_RETI;
			8'b11???111: c = pocd_pkg::CLS_RST;
			8'b11001101: c = pocd_pkg::CLS_CALL;
			8'b110??100: c = pocd_pkg::CLS_CALL;
			8'b11001110: c = pocd_pkg::CLS_ADC;
			8'b10001???: c = pocd_pkg::CLS_ADC;
			8'b10010???: c = pocd_pkg::CLS_SUB;
			8'b11010110: c = pocd_pkg::CLS_SUB;
			8'b11011110: c = pocd_pkg::CLS_SBC;
			8'b10011???: c = pocd_pkg::CLS_SBC;
			8'b11100110: c = pocd_pkg::CLS_AND;
			8'b10100???: c = pocd_pkg::CLS_AND;
			8'b11110110: c = pocd_pkg::CLS_OR;
			8'b10110???: c = pocd_pkg::CLS_OR;
			8'b11101110: c = pocd_pkg::CLS_XOR;
			8'b10101???: c = pocd_pkg::CLS_XOR;
			8'b11111000: c = pocd_pkg::CLS_LDHL;
			8'b11111011: c = pocd_pkg::CLS_EI;
			8'b11110011: c = pocd_pkg::CLS_DI;
			8'b11111110: c = pocd_pkg::CLS_CP;
			8'b10111???: c = pocd_pkg::CLS_CP;
			8'b00???100: c = pocd_pkg::CLS_INC;
			8'b00??0011: c = pocd_pkg::CLS_INC;
			8'b00???101: c = pocd_pkg::CLS_DEC;
			8'b00??1011: c = pocd_pkg::CLS_DEC;
			8'b11??0101: c = pocd_pkg::CLS_PUSH;
			8'b11??0001: c = pocd_pkg::CLS_POP;
			default: begin
				c = '0;
				match_plain = 1'b0;
			end
		endcase
	endfunction

	function pocd_pkg::cls_t predict_class(input pocd_pkg::op_t item);
		pocd_pkg::cls_t r;
		pocd_pkg::cls_code_t c;
		bit hit;
		c = '0;
		if (item.prefix_valid && item.prefix_byte == pocd_pkg::PFX_CB) begin
			hit = match_cb(item.opcode_byte, c);
		end else if (item.prefix_valid &&
				(item.prefix_byte == pocd_pkg::PFX_DD ||
				item.prefix_byte == pocd_pkg::PFX_FD)) begin
			hit = match_index_load(item.opcode_byte);
			c = pocd_pkg::CLS_LD;
		end else if (item.prefix_valid && item.prefix_byte == pocd_pkg::PFX_FC) begin
			hit = (item.opcode_byte == 8'b11000011);
			c = pocd_pkg::CLS_JPU;
			if (!hit) begin
				hit = match_load(item.opcode_byte);
				c = pocd_pkg::CLS_LD;
			end
		end else begin
			hit = match_plain(item.opcode_byte, c);
			if (!hit) begin
				hit = match_load(item.opcode_byte);
				c = pocd_pkg::CLS_LD;
			end
		end
		r.unknown = !hit;
		r.instr_class = hit ? c : '0;
		return r;
	endfunction

	function void note_opcode(input pocd_pkg::op_t item);
		expected_classes.push_back(predict_class(item));
	endfunction

	function void check_class(input pocd_pkg::cls_t got);
		pocd_pkg::cls_t want;
		if (expected_classes.size() == 0) begin
			$display("%0t: class item with none expected: class %0d unknown %0b",
				$time, got.instr_class, got.unknown);
			mismatch_count++;
			return;
		end
		want = expected_classes.pop_front();
		if (got.instr_class !== want.instr_class) begin
			$display("%0t: instr_class expected %0d actual %0d",
				$time, want.instr_class, got.instr_class);
			mismatch_count++;
		end
		if (got.unknown !== want.unknown) begin
			$display("%0t: unknown expected %0b actual %0b",
				$time, want.unknown, got.unknown);
			mismatch_count++;
		end
	endfunction
endclass

module tb_prefixed_opcode_class_decoder_unit;
	logic clk;
	logic arst_n = 1'b0;
	logic op_valid = 1'b0;
	logic op_stall;
	pocd_pkg::op_t op = '0;
	logic cls_valid;
	logic cls_stall = 1'b0;
	pocd_pkg::cls_t cls;

	int idle_pct = 0;
	int stall_pct = 0;
	opcode_class_tracker tracker;

	prefixed_opcode_class_decoder_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.op_valid(op_valid),
		.op_stall(op_stall),
		.op(op),
		.cls_valid(cls_valid),
		.cls_stall(cls_stall),
		.cls(cls)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cls_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (op_valid && !op_stall)
				tracker.note_opcode(op);
			if (cls_valid && !cls_stall)
				tracker.check_class(cls);
		end
	end

	task automatic send_opcode(input logic [7:0] opc, input logic pv, input logic [7:0] pb);
		while ($urandom_range(0, 99) < idle_pct) begin
			op_valid <= 1'b0;
			@(posedge clk);
		end
		op_valid <= 1'b1;
		op <= pocd_pkg::op_t'{opcode_byte: opc, prefix_valid: pv, prefix_byte: pb};
		do @(posedge clk); while (op_stall);
	endtask

	// Mostly the four real prefixes, the rest absent or some other byte.
	task automatic send_random_opcode();
		int pick;
		logic pv;
		logic [7:0] pb;
		pick = $urandom_range(0, 99);
		pv = 1'b1;
		pb = 8'($urandom_range(0, 255));
		if (pick < 20)
			pv = 1'b0;
		else if (pick < 35)
			pb = pocd_pkg::PFX_CB;
		else if (pick < 45)
			pb = pocd_pkg::PFX_DD;
		else if (pick < 55)
			pb = pocd_pkg::PFX_FD;
		else if (pick < 70)
			pb = pocd_pkg::PFX_FC;
		send_opcode(8'($urandom_range(0, 255)), pv, pb);
	endtask

	task automatic wait_for_classes();
		op_valid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_classes.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		tracker = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Unprefixed, and prefix bytes that must fall back to the plain map.
		send_opcode(8'h00, 1'b0, 8'h00);
		send_opcode(8'hFF, 1'b0, pocd_pkg::PFX_CB);
		send_opcode(8'h76, 1'b0, 8'h00);
		send_opcode(8'hE3, 1'b0, 8'h00);
		send_opcode(8'hFC, 1'b1, 8'h00);
		send_opcode(8'hDD, 1'b1, 8'hFF);
		send_opcode(8'hC3, 1'b0, pocd_pkg::PFX_FC);
		send_opcode(8'h7F, 1'b1, 8'h01);
		send_opcode(8'hD9, 1'b1, 8'hCA);
		// Bit, rotate and shift group.
		send_opcode(8'h40, 1'b1, pocd_pkg::PFX_CB);
		send_opcode(8'h80, 1'b1, pocd_pkg::PFX_CB);
		send_opcode(8'hFF, 1'b1, pocd_pkg::PFX_CB);
		send_opcode(8'h00, 1'b1, pocd_pkg::PFX_CB);
		send_opcode(8'h37, 1'b1, pocd_pkg::PFX_CB);
		send_opcode(8'h3F, 1'b1, pocd_pkg::PFX_CB);
		// Index loads, including opcodes with no match.
		send_opcode(8'h46, 1'b1, pocd_pkg::PFX_DD);
		send_opcode(8'h70, 1'b1, pocd_pkg::PFX_FD);
		send_opcode(8'h00, 1'b1, pocd_pkg::PFX_DD);
		send_opcode(8'hFF, 1'b1, pocd_pkg::PFX_FD);
		// System-mode jump, then the load fallback.
		send_opcode(8'hC3, 1'b1, pocd_pkg::PFX_FC);
		send_opcode(8'h00, 1'b1, pocd_pkg::PFX_FC);
		send_opcode(8'h08, 1'b1, pocd_pkg::PFX_FC);
		send_opcode(8'h40, 1'b1, pocd_pkg::PFX_FC);
		wait_for_classes();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 53;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 53;
				end
				default: begin
					idle_pct = 11;
					stall_pct = 11;
				end
			endcase
			repeat (370) send_random_opcode();
			wait_for_classes();
		end
		stall_pct = 0;

		repeat (10) @(posedge clk);
		if (tracker.mismatch_count == 0 && tracker.expected_classes.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
